>>> rtl/cramer_3x3_solver_defines.svh
// Assertion macros for the solver RTL
`ifndef CRAMER_3X3_SOLVER_DEFINES_SVH
`define CRAMER_3X3_SOLVER_DEFINES_SVH

// same-cycle implication
`define C3S_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define C3S_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/c3s_pkg.sv
// Types and constants of the 3x3 Cramer solver
`timescale 1ns / 1ps
package c3s_pkg;

    localparam int COEF_W  = 16;
    localparam int PROD_W  = 32;
    localparam int MINOR_W = 33;
    localparam int TRIP_W  = 49;
    localparam int DET_W   = 51;
    localparam int DEN_W   = 48;
    localparam int NUM_W   = 64;
    localparam int FRAC_W  = 16;
    localparam int QB      = 33;
    localparam int SOL_W   = 32;
    localparam int THR_W   = 32;

    localparam logic [QB-1:0] POS_LIMIT = 33'h0_7FFF_FFFF;
    localparam logic [QB-1:0] NEG_LIMIT = 33'h0_8000_0000;
    localparam logic signed [SOL_W-1:0] SOL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SOL_W-1:0] SOL_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic signed [COEF_W-1:0] row1_coef_x;
        logic signed [COEF_W-1:0] row1_coef_y;
        logic signed [COEF_W-1:0] row1_coef_z;
        logic signed [COEF_W-1:0] row1_rhs;
        logic signed [COEF_W-1:0] row2_coef_x;
        logic signed [COEF_W-1:0] row2_coef_y;
        logic signed [COEF_W-1:0] row2_coef_z;
        logic signed [COEF_W-1:0] row2_rhs;
        logic signed [COEF_W-1:0] row3_coef_x;
        logic signed [COEF_W-1:0] row3_coef_y;
        logic signed [COEF_W-1:0] row3_coef_z;
        logic signed [COEF_W-1:0] row3_rhs;
    } sys_word_t;

    typedef struct packed {
        logic signed [SOL_W-1:0] sol_x;
        logic signed [SOL_W-1:0] sol_y;
        logic signed [SOL_W-1:0] sol_z;
        logic                    singular;
        logic                    overflow;
    } sol_word_t;

    typedef struct packed {
        logic signed [DET_W-1:0] d;
        logic signed [DET_W-1:0] dx;
        logic signed [DET_W-1:0] dy;
        logic signed [DET_W-1:0] dz;
    } det_set_t;

endpackage

>>> rtl/c3s_det.sv
// Four-stage pipeline forming the main and column-replaced determinants
`timescale 1ns / 1ps
module c3s_det (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  c3s_pkg::sys_word_t   in_word,
    output logic                 out_valid,
    output c3s_pkg::det_set_t    out_det
);

    logic [3:0] vld_reg;

    logic signed [c3s_pkg::PROD_W-1:0]  p_reg [0:11];
    logic signed [c3s_pkg::COEF_W-1:0]  r0a_reg [0:3];
    logic signed [c3s_pkg::COEF_W-1:0]  r0b_reg [0:3];
    logic signed [c3s_pkg::MINOR_W-1:0] m_reg [0:5];
    logic signed [c3s_pkg::TRIP_W-1:0]  t_reg [0:11];
    c3s_pkg::det_set_t                  det_reg;

    logic signed [c3s_pkg::MINOR_W-1:0] m_next [0:5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    // minors over rows two and three
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            m_next[i] = c3s_pkg::MINOR_W'(p_reg[2*i]) - c3s_pkg::MINOR_W'(p_reg[2*i+1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // yz, xz, xy, rz, yr, xr
            p_reg[0]  <= in_word.row2_coef_y * in_word.row3_coef_z;
            p_reg[1]  <= in_word.row3_coef_y * in_word.row2_coef_z;
            p_reg[2]  <= in_word.row2_coef_x * in_word.row3_coef_z;
            p_reg[3]  <= in_word.row3_coef_x * in_word.row2_coef_z;
            p_reg[4]  <= in_word.row2_coef_x * in_word.row3_coef_y;
            p_reg[5]  <= in_word.row3_coef_x * in_word.row2_coef_y;
            p_reg[6]  <= in_word.row2_rhs * in_word.row3_coef_z;
            p_reg[7]  <= in_word.row3_rhs * in_word.row2_coef_z;
            p_reg[8]  <= in_word.row2_coef_y * in_word.row3_rhs;
            p_reg[9]  <= in_word.row3_coef_y * in_word.row2_rhs;
            p_reg[10] <= in_word.row2_coef_x * in_word.row3_rhs;
            p_reg[11] <= in_word.row3_coef_x * in_word.row2_rhs;
            r0a_reg[0] <= in_word.row1_coef_x;
            r0a_reg[1] <= in_word.row1_coef_y;
            r0a_reg[2] <= in_word.row1_coef_z;
            r0a_reg[3] <= in_word.row1_rhs;
            r0b_reg    <= r0a_reg;
            m_reg      <= m_next;
            t_reg[0]  <= r0b_reg[0] * m_reg[0];
            t_reg[1]  <= r0b_reg[1] * m_reg[1];
            t_reg[2]  <= r0b_reg[2] * m_reg[2];
            t_reg[3]  <= r0b_reg[3] * m_reg[0];
            t_reg[4]  <= r0b_reg[1] * m_reg[3];
            t_reg[5]  <= r0b_reg[2] * m_reg[4];
            t_reg[6]  <= r0b_reg[0] * m_reg[3];
            t_reg[7]  <= r0b_reg[3] * m_reg[1];
            t_reg[8]  <= r0b_reg[2] * m_reg[5];
            t_reg[9]  <= r0b_reg[0] * m_reg[4];
            t_reg[10] <= r0b_reg[1] * m_reg[5];
            t_reg[11] <= r0b_reg[3] * m_reg[2];
            det_reg.d  <= c3s_pkg::DET_W'(t_reg[0]) - c3s_pkg::DET_W'(t_reg[1])
                        + c3s_pkg::DET_W'(t_reg[2]);
            det_reg.dx <= c3s_pkg::DET_W'(t_reg[3]) - c3s_pkg::DET_W'(t_reg[4])
                        - c3s_pkg::DET_W'(t_reg[5]);
            det_reg.dy <= c3s_pkg::DET_W'(t_reg[6]) - c3s_pkg::DET_W'(t_reg[7])
                        + c3s_pkg::DET_W'(t_reg[8]);
            det_reg.dz <= c3s_pkg::DET_W'(t_reg[9]) - c3s_pkg::DET_W'(t_reg[10])
                        + c3s_pkg::DET_W'(t_reg[11]);
        end
    end

    assign out_valid = vld_reg[3];
    assign out_det   = det_reg;

endmodule

>>> rtl/c3s_div.sv
// Pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module c3s_div (
    input  logic                          clk,
    input  logic                          en,
    input  logic [c3s_pkg::NUM_W-1:0]     num,
    input  logic [c3s_pkg::DEN_W-1:0]     den,
    input  logic                          neg_in,
    input  logic                          big_in,
    output logic [c3s_pkg::QB-1:0]        quo,
    output logic                          neg_out,
    output logic                          big_out
);

    localparam int QB   = c3s_pkg::QB;
    localparam int WIDE = c3s_pkg::NUM_W + QB;

    logic [c3s_pkg::NUM_W-1:0] rem_reg [0:QB-1];
    logic [QB-1:0]             q_reg   [0:QB-1];
    logic [c3s_pkg::DEN_W-1:0] den_reg [0:QB-1];
    logic                      neg_reg [0:QB-1];
    logic                      big_reg [0:QB-1];

    genvar g;
    generate
        for (g = 0; g < QB; g++)
        begin : g_stage
            localparam int K = QB - 1 - g;
            logic [c3s_pkg::NUM_W-1:0] rem_in;
            logic [QB-1:0]             q_in;
            logic [c3s_pkg::DEN_W-1:0] den_in;
            logic                      neg_i;
            logic                      big_i;
            logic [WIDE-1:0]           shifted;
            logic                      take;

            if (g == 0)
            begin : g_first
                assign rem_in = num;
                assign q_in   = '0;
                assign den_in = den;
                assign neg_i  = neg_in;
                assign big_i  = big_in;
            end
            else
            begin : g_rest
                assign rem_in = rem_reg[g-1];
                assign q_in   = q_reg[g-1];
                assign den_in = den_reg[g-1];
                assign neg_i  = neg_reg[g-1];
                assign big_i  = big_reg[g-1];
            end

            assign shifted = WIDE'(den_in) << K;
            assign take    = WIDE'(rem_in) >= shifted;

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[g] <= take ? rem_in - shifted[c3s_pkg::NUM_W-1:0] : rem_in;
                    q_reg[g]   <= q_in | (QB'(take) << K);
                    den_reg[g] <= den_in;
                    neg_reg[g] <= neg_i;
                    big_reg[g] <= big_i;
                end
            end
        end
    endgenerate

    assign quo     = q_reg[QB-1];
    assign neg_out = neg_reg[QB-1];
    assign big_out = big_reg[QB-1];

endmodule

>>> rtl/cramer_3x3_solver.sv
// Top level of the pipelined 3x3 Cramer solver
`timescale 1ns / 1ps
// Solves one 3x3 system per word and takes a new word every cycle while not
// stalled. Four stages form the determinants, one stage takes magnitudes and
// checks for singularity, 33 stages of the restoring divider give one quotient
// bit each, and the last stage saturates into the output register. A stalled
// output freezes the whole pipeline; cfg_ready is always high.
`include "cramer_3x3_solver_defines.svh"
module cramer_3x3_solver (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [31:0]          cfg_data,
    input  logic                 sys_valid,
    output logic                 sys_stall,
    input  c3s_pkg::sys_word_t   sys,
    output logic                 sol_valid,
    input  logic                 sol_stall,
    output c3s_pkg::sol_word_t   sol
);

    localparam int QB = c3s_pkg::QB;

    logic [c3s_pkg::THR_W-1:0] thresh_reg;
    logic                      adv;
    logic                      det_valid;
    c3s_pkg::det_set_t         det;

    logic                      s5_valid_reg;
    logic                      s5_sing_reg;
    logic [c3s_pkg::NUM_W-1:0] s5_num_reg [0:2];
    logic [c3s_pkg::DEN_W-1:0] s5_den_reg;
    logic                      s5_neg_reg [0:2];
    logic                      s5_big_reg [0:2];

    logic [QB-1:0]             vld_reg;
    logic [QB-1:0]             sing_reg;

    logic                      sol_valid_reg;
    c3s_pkg::sol_word_t        sol_reg;
    c3s_pkg::sol_word_t        sol_next;

    logic signed [c3s_pkg::DET_W-1:0] dn [0:2];
    logic [c3s_pkg::DET_W-1:0] d_abs;
    logic [c3s_pkg::DET_W-1:0] n_abs [0:2];
    logic [c3s_pkg::NUM_W-1:0] num_next [0:2];
    logic                      big_next [0:2];
    logic [QB-1:0]             quo [0:2];
    logic                      qneg [0:2];
    logic                      qbig [0:2];
    logic signed [c3s_pkg::SOL_W-1:0] lane_sol [0:2];
    logic                      lane_ovf [0:2];

    assign adv       = !sol_valid_reg || !sol_stall;
    assign sys_stall = !adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg <= '0;
        end
        else if (cfg_valid)
        begin
            thresh_reg <= cfg_data;
        end
    end

    c3s_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (sys_valid),
        .in_word   (sys),
        .out_valid (det_valid),
        .out_det   (det)
    );

    assign dn[0] = det.dx;
    assign dn[1] = det.dy;
    assign dn[2] = det.dz;
    assign d_abs = det.d[c3s_pkg::DET_W-1] ? -det.d : det.d;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n_abs[i]    = dn[i][c3s_pkg::DET_W-1] ? -dn[i] : dn[i];
            num_next[i] = {n_abs[i][c3s_pkg::DEN_W-1:0], {c3s_pkg::FRAC_W{1'b0}}};
            big_next[i] = c3s_pkg::DEN_W'(num_next[i][c3s_pkg::NUM_W-1:QB])
                          >= d_abs[c3s_pkg::DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_valid_reg  <= 1'b0;
            vld_reg       <= '0;
            sol_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s5_valid_reg  <= det_valid;
            vld_reg       <= {vld_reg[QB-2:0], s5_valid_reg};
            sol_valid_reg <= vld_reg[QB-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_sing_reg <= d_abs[c3s_pkg::DEN_W-1:0]
                           <= c3s_pkg::DEN_W'(thresh_reg);
            s5_den_reg  <= d_abs[c3s_pkg::DEN_W-1:0];
            for (int i = 0; i < 3; i++)
            begin
                s5_num_reg[i] <= num_next[i];
                s5_neg_reg[i] <= dn[i][c3s_pkg::DET_W-1] ^ det.d[c3s_pkg::DET_W-1];
                s5_big_reg[i] <= big_next[i];
            end
            sing_reg <= {sing_reg[QB-2:0], s5_sing_reg};
            sol_reg  <= sol_next;
        end
    end

    genvar l;
    generate
        for (l = 0; l < 3; l++)
        begin : g_lane
            c3s_div u_div (
                .clk     (clk),
                .en      (adv),
                .num     (s5_num_reg[l]),
                .den     (s5_den_reg),
                .neg_in  (s5_neg_reg[l]),
                .big_in  (s5_big_reg[l]),
                .quo     (quo[l]),
                .neg_out (qneg[l]),
                .big_out (qbig[l])
            );

            always_comb
            begin
                if (qneg[l])
                begin
                    lane_ovf[l] = qbig[l] || (quo[l] > c3s_pkg::NEG_LIMIT);
                    lane_sol[l] = lane_ovf[l] ? c3s_pkg::SOL_MIN
                                              : -c3s_pkg::SOL_W'(quo[l]);
                end
                else
                begin
                    lane_ovf[l] = qbig[l] || (quo[l] > c3s_pkg::POS_LIMIT);
                    lane_sol[l] = lane_ovf[l] ? c3s_pkg::SOL_MAX
                                              : c3s_pkg::SOL_W'(quo[l]);
                end
            end
        end
    endgenerate

    always_comb
    begin
        if (sing_reg[QB-1])
        begin
            sol_next = '0;
            sol_next.singular = 1'b1;
        end
        else
        begin
            sol_next.sol_x    = lane_sol[0];
            sol_next.sol_y    = lane_sol[1];
            sol_next.sol_z    = lane_sol[2];
            sol_next.singular = 1'b0;
            sol_next.overflow = lane_ovf[0] || lane_ovf[1] || lane_ovf[2];
        end
    end

    assign sol_valid = sol_valid_reg;
    assign sol       = sol_reg;

    `C3S_ASSERT_IMP(a_sing_zero, sol_valid && sol.singular,
        sol.sol_x == 0 && sol.sol_y == 0 && sol.sol_z == 0 && !sol.overflow,
        "singular word carries nonzero solution")
    `C3S_ASSERT_IMP(a_ovf_sat, sol_valid && sol.overflow,
        sol.sol_x == c3s_pkg::SOL_MAX || sol.sol_x == c3s_pkg::SOL_MIN ||
        sol.sol_y == c3s_pkg::SOL_MAX || sol.sol_y == c3s_pkg::SOL_MIN ||
        sol.sol_z == c3s_pkg::SOL_MAX || sol.sol_z == c3s_pkg::SOL_MIN,
        "overflow without a saturated lane")
    `C3S_ASSERT_NXT(a_hold_pipe, !adv,
        $stable(vld_reg) && $stable(s5_valid_reg),
        "pipeline moved while stalled")

endmodule
